// ===== sv/hsv_palette_tint_assert.svh =====
// Assertion macros used by the hsv_palette_tint queue.
`ifndef HSV_PALETTE_TINT_ASSERT_SVH
`define HSV_PALETTE_TINT_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define HPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hpt_pkg.sv =====
// Types and constants shared by the hsv_palette_tint modules.
package hpt_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } tinted_t;

  typedef enum logic [1:0] {
    HUE_RED,
    HUE_GREEN,
    HUE_BLUE
  } hue_base_t;

  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

  typedef struct packed {
    hue_base_t   hue_base;
    logic        hue_neg;
    logic [20:0] hue_num;
    logic [8:0]  hue_den;
    logic        sat_zero;
    logic [24:0] sat_num;
    logic [8:0]  sat_den;
    logic [7:0]  vmax;
  } cls_t;

  typedef struct packed {
    cls_t pix;
    cls_t tint;
  } item_t;

  localparam logic [1:0] REG_TINT_RED   = 2'd0;
  localparam logic [1:0] REG_TINT_GREEN = 2'd1;
  localparam logic [1:0] REG_TINT_BLUE  = 2'd2;

  localparam logic [7:0] NEAR_COUNT = 8'd2;

endpackage

// ===== sv/hpt_front.sv =====
// Front stage: takes pixel transfers and classifies pixel and tint for the hue and saturation divides.
module hpt_front import hpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pixel_t     pixel,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic [7:0] tint_red,
  input  logic [7:0] tint_green,
  input  logic [7:0] tint_blue,
  output item_t      item,
  output logic       push,
  input  logic       q_full
);

  function automatic cls_t classify(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] delta;
    logic [7:0] a;
    logic [7:0] c;
    logic       hz;
    logic [7:0] mag;
    cls_t       res;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hz = (delta <= NEAR_COUNT);
    if (mx - r <= NEAR_COUNT) begin
      res.hue_base = HUE_RED;
      a = g;
      c = b;
    end else if (mx - g <= NEAR_COUNT) begin
      res.hue_base = HUE_GREEN;
      a = b;
      c = r;
    end else begin
      res.hue_base = HUE_BLUE;
      a = r;
      c = g;
    end
    if (hz) begin
      res.hue_base = HUE_RED;
      a = 8'd0;
      c = 8'd0;
    end
    res.hue_neg = (a < c);
    mag = res.hue_neg ? c - a : a - c;
    res.hue_num = hz ? 21'd0 : (21'(mag) << 13) - (21'(mag) << 9) + 21'(delta);
    res.hue_den = hz ? 9'd2 : {delta, 1'b0};
    res.sat_zero = (mx <= NEAR_COUNT);
    res.sat_num = (25'(delta) << 17) - (25'(delta) << 1) + 25'(mx);
    res.sat_den = res.sat_zero ? 9'd2 : {mx, 1'b0};
    res.vmax = mx;
    return res;
  endfunction

  logic  fv;
  logic  accept;
  item_t item_next;

  assign pixel_stall = fv & q_full;
  assign push        = fv & ~q_full;
  assign accept      = pixel_valid & ~pixel_stall;

  always_comb begin
    item_next.pix  = classify(pixel.in_red, pixel.in_green, pixel.in_blue);
    item_next.tint = classify(tint_red, tint_green, tint_blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= accept | (fv & ~push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

// ===== sv/hpt_queue.sv =====
// Short queue between the front stage and the arithmetic pipeline.
`include "hsv_palette_tint_assert.svh"
module hpt_queue import hpt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  input  logic  pop,
  output item_t rdata,
  output logic  full,
  output logic  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  `HPT_ASSERT_NEXT(a_cnt_up, push && !pop, cnt == $past(cnt) + 1'b1, "Queue count did not rise.")
  `HPT_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt == $past(cnt) - 1'b1, "Queue count did not fall.")
  `HPT_ASSERT_NOW(a_no_ovf, full, !push, "Write into a full queue.")
  `HPT_ASSERT_NOW(a_no_unf, empty, !pop, "Read from an empty queue.")

endmodule

// ===== sv/hpt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module hpt_div #(
  parameter int NW = 25,
  parameter int DW = 9,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int W = NW + DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [W-1:0]  dsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
    end

    assign dsh = W'(d_in) << (QW - 1 - k);
    assign ge  = (W'(r_in) >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? NW'(W'(r_in) - dsh) : r_in;
        den_q[k] <= d_in;
        quo_q[k] <= q_in | (ge ? (QW'(1) << (QW - 1 - k)) : '0);
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== sv/hpt_back.sv =====
// Arithmetic pipeline: divides, tinting and HSV to RGB conversion with the output register.
module hpt_back import hpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   q_item,
  input  logic    q_empty,
  output logic    pop,
  output tinted_t tinted,
  output logic    tinted_valid,
  input  logic    tinted_stall
);

  localparam int DivStages = 16;

  typedef struct packed {
    hue_base_t  pb;
    logic       pn;
    logic       pz;
    logic [7:0] pm;
    hue_base_t  tb;
    logic       tn;
    logic       tz;
    logic [7:0] tm;
  } side_t;

  function automatic logic [15:0] frac_div(input logic [31:0] p);
    logic [31:0] u;
    logic [15:0] q0;
    logic [16:0] r;
    u  = p + 32'd32767;
    q0 = u[31:16];
    r  = {1'b0, u[15:0]} + {1'b0, q0};
    return (r >= 17'd65535) ? q0 + 16'd1 : q0;
  endfunction

  function automatic logic signed [16:0] hue_value(input hue_base_t base, input logic neg,
                                                   input logic [15:0] q);
    logic signed [16:0] off;
    logic signed [16:0] qs;
    case (base)
      HUE_GREEN: off = 17'sd7680;
      HUE_BLUE:  off = 17'sd15360;
      default:   off = 17'sd0;
    endcase
    qs = $signed({5'b0, q[11:0]});
    return neg ? off - qs : off + qs;
  endfunction

  function automatic logic [7:0] clamp_count(input logic [33:0] p);
    logic [9:0] q;
    q = p[33:24];
    return (q > 10'd255) ? 8'd255 : q[7:0];
  endfunction

  logic en;
  assign en  = ~tinted_valid | ~tinted_stall;
  assign pop = en & ~q_empty;

  logic [15:0] hq_p, sq_p, hq_t, sq_t;

  hpt_div #(.NW(21), .DW(9), .QW(DivStages)) u_hue_pix (
    .clk(clk), .en(en), .num(q_item.pix.hue_num), .den(q_item.pix.hue_den), .quo(hq_p));
  hpt_div #(.NW(25), .DW(9), .QW(DivStages)) u_sat_pix (
    .clk(clk), .en(en), .num(q_item.pix.sat_num), .den(q_item.pix.sat_den), .quo(sq_p));
  hpt_div #(.NW(21), .DW(9), .QW(DivStages)) u_hue_tint (
    .clk(clk), .en(en), .num(q_item.tint.hue_num), .den(q_item.tint.hue_den), .quo(hq_t));
  hpt_div #(.NW(25), .DW(9), .QW(DivStages)) u_sat_tint (
    .clk(clk), .en(en), .num(q_item.tint.sat_num), .den(q_item.tint.sat_den), .quo(sq_t));

  side_t                side [DivStages];
  logic [DivStages-1:0] dv;
  logic [8:0]           pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv           <= '0;
      pv           <= '0;
      tinted_valid <= 1'b0;
    end else if (en) begin
      dv           <= {dv[DivStages-2:0], pop};
      pv           <= {pv[7:0], dv[DivStages-1]};
      tinted_valid <= pv[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{pb: q_item.pix.hue_base, pn: q_item.pix.hue_neg,
                   pz: q_item.pix.sat_zero, pm: q_item.pix.vmax,
                   tb: q_item.tint.hue_base, tn: q_item.tint.hue_neg,
                   tz: q_item.tint.sat_zero, tm: q_item.tint.vmax};
      for (int i = 1; i < DivStages; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  logic signed [16:0] h1_p, h1_t;
  logic [15:0]        s1_p, s1_t, v1_p, v1_t;
  logic signed [17:0] hs, hw1, hw2;
  logic [14:0]        h2;
  logic [31:0]        ps2, pv2;
  logic [14:0]        hoff, f3;
  sector_t            sec_n;
  logic [11:0]        d_n;
  logic [15:0]        s3, v3;
  sector_t            sec3, sec4, sec5, sec6, sec7;
  logic [11:0]        d3, d4;
  logic [31:0]        pc4;
  logic [15:0]        v4;
  logic [15:0]        c5, m5, c6, m6, c7, m7;
  logic [11:0]        w5;
  logic [27:0]        y6;
  logic [39:0]        p7;
  logic [15:0]        x8, cr, cg, cb;
  logic [16:0]        w8_r, w8_g, w8_b;
  logic [33:0]        p9_r, p9_g, p9_b;

  always_comb begin
    hs  = {h1_p[16], h1_p} + {h1_t[16], h1_t};
    hw1 = (hs < 18'sd0) ? hs + 18'sd23040 : hs;
    hw2 = (hw1 > 18'sd23040) ? hw1 - 18'sd23040 : hw1;
  end

  always_comb begin
    if (h2 >= 15'd19200) sec_n = SEC_MR;
    else if (h2 >= 15'd15360) sec_n = SEC_BM;
    else if (h2 >= 15'd11520) sec_n = SEC_CB;
    else if (h2 >= 15'd7680) sec_n = SEC_GC;
    else if (h2 >= 15'd3840) sec_n = SEC_YG;
    else sec_n = SEC_RY;
    if (h2 >= 15'd15360) hoff = 15'd15360;
    else if (h2 >= 15'd7680) hoff = 15'd7680;
    else hoff = 15'd0;
    f3  = h2 - hoff;
    d_n = (f3 > 15'd3840) ? 12'(f3 - 15'd3840) : 12'(15'd3840 - f3);
  end

  always_comb begin
    x8 = p7[38:23];
    case (sec7)
      SEC_RY:  begin cr = c7;    cg = x8;    cb = 16'd0; end
      SEC_YG:  begin cr = x8;    cg = c7;    cb = 16'd0; end
      SEC_GC:  begin cr = 16'd0; cg = c7;    cb = x8;    end
      SEC_CB:  begin cr = 16'd0; cg = x8;    cb = c7;    end
      SEC_BM:  begin cr = x8;    cg = 16'd0; cb = c7;    end
      default: begin cr = c7;    cg = 16'd0; cb = x8;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_p <= hue_value(side[DivStages-1].pb, side[DivStages-1].pn, hq_p);
      h1_t <= hue_value(side[DivStages-1].tb, side[DivStages-1].tn, hq_t);
      s1_p <= side[DivStages-1].pz ? 16'd0 : sq_p;
      s1_t <= side[DivStages-1].tz ? 16'd0 : sq_t;
      v1_p <= {side[DivStages-1].pm, side[DivStages-1].pm};
      v1_t <= {side[DivStages-1].tm, side[DivStages-1].tm};

      h2  <= hw2[14:0];
      ps2 <= s1_p * s1_t;
      pv2 <= v1_p * v1_t;

      s3   <= frac_div(ps2);
      v3   <= frac_div(pv2);
      sec3 <= sec_n;
      d3   <= d_n;

      pc4  <= v3 * s3;
      v4   <= v3;
      sec4 <= sec3;
      d4   <= d3;

      c5   <= frac_div(pc4);
      m5   <= v4 - frac_div(pc4);
      w5   <= 12'd3840 - d4;
      sec5 <= sec4;

      y6   <= 28'(c5) * 28'(w5) + 28'd1920;
      c6   <= c5;
      m6   <= m5;
      sec6 <= sec5;

      p7   <= 40'(y6[27:8]) * 40'd559241;
      c7   <= c6;
      m7   <= m6;
      sec7 <= sec6;

      w8_r <= 17'(cr) + 17'(m7) + 17'd128;
      w8_g <= 17'(cg) + 17'(m7) + 17'd128;
      w8_b <= 17'(cb) + 17'(m7) + 17'd128;

      p9_r <= 34'(w8_r) * 34'd65281;
      p9_g <= 34'(w8_g) * 34'd65281;
      p9_b <= 34'(w8_b) * 34'd65281;

      tinted.out_red   <= clamp_count(p9_r);
      tinted.out_green <= clamp_count(p9_g);
      tinted.out_blue  <= clamp_count(p9_b);
    end
  end

endmodule

// ===== sv/hsv_palette_tint.sv =====
// Top level of the HSV palette tint block: register port, front stage, queue and pipeline.
//
//   channel  direction  handshake                  payload
//   pixel    in         pixel_valid / pixel_stall  pixel_t
//   tinted   out        tinted_valid / tinted_stall tinted_t
//   apb      in         psel / penable / pready    tint_red, tint_green, tint_blue
//
// One pixel transfer per cycle is sustained while tinted is not stalled.
// The path from pixel to tinted is the front register, the queue storage, the 16-stage dividers
// (four in parallel) and ten stages of arithmetic after them.
// Reset is synchronous; it empties the pipeline and queue and loads the tint to pure red.
// A stall on tinted while tinted_valid is high freezes the pipeline; the queue then fills and pixel_stall rises.
module hsv_palette_tint import hpt_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  pixel_t      pixel,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  output tinted_t     tinted,
  output logic        tinted_valid,
  input  logic        tinted_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] tint_red;
  logic [7:0] tint_green;
  logic [7:0] tint_blue;
  logic       wr;
  item_t      f_item;
  item_t      q_item;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint_red   <= 8'd255;
      tint_green <= 8'd0;
      tint_blue  <= 8'd0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_TINT_RED:   tint_red   <= pwdata[7:0];
        REG_TINT_GREEN: tint_green <= pwdata[7:0];
        REG_TINT_BLUE:  tint_blue  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TINT_RED:   prdata = {24'd0, tint_red};
      REG_TINT_GREEN: prdata = {24'd0, tint_green};
      REG_TINT_BLUE:  prdata = {24'd0, tint_blue};
      default:        prdata = 32'd0;
    endcase
  end

  hpt_front u_front (
    .clk(clk), .rst(rst), .pixel(pixel), .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall), .tint_red(tint_red), .tint_green(tint_green),
    .tint_blue(tint_blue), .item(f_item), .push(push), .q_full(q_full));

  hpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(f_item), .pop(pop),
    .rdata(q_item), .full(q_full), .empty(q_empty));

  hpt_back u_back (
    .clk(clk), .rst(rst), .q_item(q_item), .q_empty(q_empty), .pop(pop),
    .tinted(tinted), .tinted_valid(tinted_valid), .tinted_stall(tinted_stall));

endmodule
